// File: src/envelope_oscillator_voice_assert.svh
// assertion macros for the envelope oscillator voice
`ifndef ENVELOPE_OSCILLATOR_VOICE_ASSERT_SVH
`define ENVELOPE_OSCILLATOR_VOICE_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define EOV_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("envelope voice check failed");
// next-cycle implication
`define EOV_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("envelope voice check failed");
`endif

// File: src/eov_pkg.sv
// shared constants, codes and sine table function for the envelope voice
`timescale 1ns / 1ps
package eov_pkg;
	localparam int TABLE_BITS_DEF  = 8;
	localparam int OSC_MAX_DEF     = 4;
	localparam int PHASE_WIDTH_DEF = 24;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_STEP  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	localparam logic [1:0] WAVE_SQUARE   = 2'd0;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [1:0] WAVE_NOISE    = 2'd2;
	localparam logic [1:0] WAVE_SINE     = 2'd3;

	localparam logic [1:0] STG_IDLE    = 2'd0;
	localparam logic [1:0] STG_ATTACK  = 2'd1;
	localparam logic [1:0] STG_SUSTAIN = 2'd2;
	localparam logic [1:0] STG_RELEASE = 2'd3;

	localparam logic [16:0] GAIN_ONE       = 17'd65536;
	localparam logic [16:0] THRESH_RESET   = 17'd33;
	localparam logic [16:0] FRACTION_RESET = 17'd63570;

	localparam int CFG_SILENCE  = 0;
	localparam int CFG_FRACTION = 1;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// q15 sine of (pi/2)*j/2^qbits, integer taylor series in q30
	function automatic longint quarter_sine(input int unsigned j, input int qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned t;
		longint sum;
		x = (HALF_PI_Q30 * longint'(j)) >> qbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			t = (term * x2) >> 30;
			unique case (k)
				1: term = t / 6;
				2: term = t / 20;
				3: term = t / 42;
				4: term = t / 72;
				5: term = t / 110;
				6: term = t / 156;
				default: term = t / 210;
			endcase
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		sum = (sum + 16384) >>> 15;
		if (sum > 32768) sum = 32768;
		return sum;
	endfunction

	function automatic logic signed [16:0] sine_entry(input int i, input int tbits);
		int unsigned q;
		int unsigned j;
		int unsigned qs;
		longint v;
		qs = 1 << (tbits - 2);
		q = i >> (tbits - 2);
		j = i & (qs - 1);
		v = (q % 2 == 1) ? quarter_sine(qs - j, tbits - 2) : quarter_sine(j, tbits - 2);
		if (q / 2 % 2 == 1) v = -v;
		return 17'(v);
	endfunction
endpackage

// File: src/envelope_oscillator_voice.sv
// envelope oscillator voice: adsr or decay envelope driving a wavetable voice
//
// channels: one input beat per request (tick, oscillator step, note start) on
// in_valid/in_ready; one output beat per tick on out_valid/out_ready; an apb
// port writes silence_threshold (0x0) and attack_done_fraction (0x4).
// step and start beats leave the voice idle, except that an adsr start then
// staggers the phases in a bit-serial divider.
// a tick runs through one shared shift-add multiplier, one bit of a 17-bit
// operand per cycle:
//   envelope 0, 1 or 2 products, sine 1 product per oscillator, output 1 product
// a silent tick skips the multiplier and leaves a zero sample.
// the next beat is taken once a tick has left its result in the output register.
// reset clears the envelope, phases, steps and noise register and loads the
// register defaults; the sine table is constant logic.
// a stalled receiver holds the result in the output register; a following
// tick waits at its end for the register to drain.
`timescale 1ns / 1ps
module envelope_oscillator_voice #(
	parameter int TABLE_BITS  = eov_pkg::TABLE_BITS_DEF,
	parameter int OSC_MAX     = eov_pkg::OSC_MAX_DEF,
	parameter int PHASE_WIDTH = eov_pkg::PHASE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [1:0]         osc_index,
	input  logic [22:0]        phase_step,
	input  logic [1:0]         wave_kind,
	input  logic [2:0]         osc_count,
	input  logic               envelope_mode,
	input  logic [16:0]        peak_level,
	input  logic [23:0]        rise_coef,
	input  logic [23:0]        fall_coef,
	input  logic [23:0]        hold_samples,
	input  logic [31:0]        noise_seed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] sample_out,
	output logic               voice_active,
	output logic [1:0]         stage_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int TBL_SIZE = 1 << TABLE_BITS;
	localparam int FRAC_W   = PHASE_WIDTH - TABLE_BITS;
	localparam int WAVE_W   = $clog2(OSC_MAX * 32768 + 1) + 1;
	localparam int MB       = 17;
	localparam int MA0      = (FRAC_W > 24) ? FRAC_W : 24;
	localparam int MA       = (WAVE_W > MA0) ? WAVE_W : MA0;
	localparam int PW_P     = MA + MB;
	localparam int Y_W      = FRAC_W + 20;
	localparam int CNT_W    = $clog2(OSC_MAX + 1);
	localparam int IDX_W    = (OSC_MAX > 1) ? $clog2(OSC_MAX) : 1;
	localparam int R_W      = $clog2(OSC_MAX) + 2;
	localparam int BIT_W    = $clog2(PHASE_WIDTH + 1);
	localparam int MC_W     = $clog2(MB + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_ENV   = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_MDONE = 4'd4;
	localparam logic [3:0] ST_WAVE  = 4'd5;
	localparam logic [3:0] ST_SINA  = 4'd6;
	localparam logic [3:0] ST_SINB  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	localparam logic [2:0] OP_DECAY = 3'd0;
	localparam logic [2:0] OP_REL   = 3'd1;
	localparam logic [2:0] OP_ATK   = 3'd2;
	localparam logic [2:0] OP_CMP   = 3'd3;
	localparam logic [2:0] OP_SIN   = 3'd4;
	localparam logic [2:0] OP_OUT   = 3'd5;

	logic [3:0]  state_q;
	logic [2:0]  op_q;
	logic [16:0] thresh_q;
	logic [16:0] fraction_q;
	logic        sounding_q;
	logic        adsr_q;
	logic [1:0]  wave_sel_q;
	logic [CNT_W-1:0] osc_n_q;
	logic [1:0]  stage_q;
	logic [16:0] level_q;
	logic [16:0] target_q;
	logic [23:0] atk_m_q;
	logic [23:0] rel_m_q;
	logic [23:0] hold_q;
	logic [PHASE_WIDTH-1:0] phase_q [OSC_MAX];
	logic [PHASE_WIDTH-1:0] step_q [OSC_MAX];
	logic [31:0] noise_q;

	logic [MA-1:0]   mul_a_q;
	logic [MB-1:0]   mul_b_q;
	logic [PW_P-1:0] mul_p_q;
	logic [MC_W-1:0] mul_cnt_q;
	logic            neg_q;

	logic [CNT_W-1:0]       k_q;
	logic [R_W-1:0]         div_r_q;
	logic [BIT_W-1:0]       div_bit_q;
	logic [PHASE_WIDTH-1:0] div_q_q;

	logic signed [WAVE_W-1:0] wave_q;
	logic signed [16:0]       sin_a_q;

	logic signed [17:0] res_smp_q;
	logic               res_act_q;
	logic               out_valid_q;
	logic signed [17:0] sample_q;
	logic               active_q;
	logic [1:0]         stage_out_q;

	// constant sine table
	logic signed [16:0] sine_rom [TBL_SIZE];
	for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
		assign sine_rom[g] = eov_pkg::sine_entry(g, TABLE_BITS);
	end

	logic                   in_fire;
	logic                   cfg_wr;
	logic                   out_load;
	logic [PHASE_WIDTH+23:0] step_wide;
	logic [PHASE_WIDTH-1:0] step_ph;
	logic [16:0]            peak_sat;
	logic [2:0]             n_clamp;
	logic [IDX_W-1:0]       k_idx;
	logic [PHASE_WIDTH-1:0] ph_k;
	logic [TABLE_BITS-1:0]  tab_idx;
	logic signed [16:0]     tab_val;
	logic [MA:0]            mul_sum;
	logic [16:0]            q24;
	logic [R_W-1:0]         div_r2;
	logic                   div_ge;
	logic [31:0]            nx1, nx2, nx3;
	logic [14:0]            tri_t;
	logic signed [18:0]     tri_v;
	logic signed [Y_W-1:0]  y_a, y_p, y_sum, y_sh;
	logic signed [16:0]     sin_v;
	logic [WAVE_W-1:0]      wave_abs;
	logic [PW_P:0]          rnd;
	logic [PW_P-16:0]       rmag;
	logic signed [17:0]     smp;
	logic [16:0]            lvl_dec;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign step_wide = {1'b0, phase_step, {PHASE_WIDTH{1'b0}}} >> 24;
	assign step_ph   = step_wide[PHASE_WIDTH-1:0];
	assign peak_sat  = (peak_level > eov_pkg::GAIN_ONE) ? eov_pkg::GAIN_ONE : peak_level;

	always_comb begin
		if (osc_count == 3'd0) n_clamp = 3'd1;
		else if (32'(osc_count) > OSC_MAX) n_clamp = 3'(OSC_MAX);
		else n_clamp = osc_count;
	end

	assign k_idx   = k_q[IDX_W-1:0];
	assign ph_k    = phase_q[k_idx];
	assign tab_idx = (state_q == ST_SINB) ? ph_k[PHASE_WIDTH-1 -: TABLE_BITS] + 1'b1
		: ph_k[PHASE_WIDTH-1 -: TABLE_BITS];
	assign tab_val = sine_rom[tab_idx];

	// shift-add: add the multiplicand on a set low bit, then shift right
	assign mul_sum = {1'b0, mul_p_q[PW_P-1:MB]} + (mul_b_q[0] ? {1'b0, mul_a_q} : '0);
	assign q24     = mul_p_q[24 +: 17];

	assign div_r2 = {div_r_q[R_W-2:0], 1'b0};
	assign div_ge = div_r2 >= R_W'(osc_n_q);

	assign nx1 = noise_q ^ (noise_q << 13);
	assign nx2 = nx1 ^ (nx1 >> 17);
	assign nx3 = nx2 ^ (nx2 << 5);

	assign tri_t = phase_q[0][PHASE_WIDTH-1 -: 15];
	assign tri_v = (tri_t < 15'd16384) ? $signed({2'b00, tri_t, 2'b00}) - 19'sd32768
		: 19'sd98304 - $signed({2'b00, tri_t, 2'b00});

	// interpolation: a*2^F + (b-a)*frac + half, floored
	always_comb begin
		y_a   = Y_W'(sin_a_q) <<< FRAC_W;
		y_p   = $signed({3'b000, mul_p_q[FRAC_W+16:0]});
		if (neg_q) y_p = -y_p;
		y_sum = y_a + y_p + (Y_W'(1) <<< (FRAC_W - 1));
		y_sh  = y_sum >>> FRAC_W;
		sin_v = y_sh[16:0];
	end

	assign wave_abs = wave_q[WAVE_W-1] ? WAVE_W'(-wave_q) : WAVE_W'(wave_q);

	// output rounding half away from zero, then saturation
	always_comb begin
		rnd  = {1'b0, mul_p_q} + (PW_P+1)'(32768);
		rmag = rnd[PW_P:16];
		if (!neg_q) smp = (rmag > (PW_P-15)'(131071)) ? 18'sd131071 : $signed(rmag[17:0]);
		else smp = (rmag > (PW_P-15)'(131072)) ? -18'sd131072 : -$signed(rmag[17:0]);
	end

	always_comb begin
		unique case (paddr[2])
			1'b0: prdata = {15'd0, thresh_q};
			default: prdata = {15'd0, fraction_q};
		endcase
	end

	assign lvl_dec = q24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_DECAY;
			thresh_q <= eov_pkg::THRESH_RESET;
			fraction_q <= eov_pkg::FRACTION_RESET;
			sounding_q <= 1'b0;
			adsr_q <= 1'b0;
			wave_sel_q <= eov_pkg::WAVE_SQUARE;
			osc_n_q <= CNT_W'(1);
			stage_q <= eov_pkg::STG_IDLE;
			level_q <= '0;
			target_q <= '0;
			atk_m_q <= '0;
			rel_m_q <= '0;
			hold_q <= '0;
			noise_q <= '0;
			for (int i = 0; i < OSC_MAX; i++) begin
				phase_q[i] <= '0;
				step_q[i] <= '0;
			end
			mul_cnt_q <= '0;
			k_q <= '0;
			div_bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (32'(paddr[2]) == eov_pkg::CFG_SILENCE) thresh_q <= pwdata[16:0];
				else fraction_q <= pwdata[16:0];
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (req_type == eov_pkg::REQ_STEP) begin
							if (32'(osc_index) < OSC_MAX) step_q[osc_index[IDX_W-1:0]] <= step_ph;
						end else if (req_type == eov_pkg::REQ_START) begin
							sounding_q <= 1'b1;
							wave_sel_q <= wave_kind;
							rel_m_q <= fall_coef;
							if (envelope_mode) begin
								adsr_q <= 1'b1;
								osc_n_q <= CNT_W'(n_clamp);
								target_q <= peak_sat;
								atk_m_q <= rise_coef;
								hold_q <= hold_samples;
								stage_q <= eov_pkg::STG_ATTACK;
								k_q <= '0;
								div_r_q <= '0;
								div_bit_q <= BIT_W'(PHASE_WIDTH);
								state_q <= ST_DIV;
							end else begin
								adsr_q <= 1'b0;
								osc_n_q <= CNT_W'(1);
								phase_q[0] <= '0;
								level_q <= peak_sat;
								noise_q <= noise_seed;
								stage_q <= eov_pkg::STG_IDLE;
							end
						end else if (req_type == eov_pkg::REQ_TICK) begin
							if (!sounding_q) begin
								res_smp_q <= '0;
								res_act_q <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_ENV;
							end
						end
					end
				end
				ST_DIV: begin
					// restoring division of k * 2^PHASE_WIDTH by the oscillator count
					div_q_q <= {div_q_q[PHASE_WIDTH-2:0], div_ge};
					if (div_bit_q == BIT_W'(1)) begin
						phase_q[k_idx] <= {div_q_q[PHASE_WIDTH-2:0], div_ge};
						k_q <= k_q + 1'b1;
						div_r_q <= R_W'(k_q + 1'b1);
						div_bit_q <= BIT_W'(PHASE_WIDTH);
						if (k_q + 1'b1 == osc_n_q) state_q <= ST_IDLE;
					end else begin
						div_r_q <= div_ge ? div_r2 - R_W'(osc_n_q) : div_r2;
						div_bit_q <= div_bit_q - 1'b1;
					end
				end
				ST_ENV: begin
					if (!adsr_q) begin
						mul_a_q <= MA'(rel_m_q);
						mul_b_q <= level_q;
						op_q <= OP_DECAY;
						mul_p_q <= '0;
						mul_cnt_q <= MC_W'(MB);
						state_q <= ST_MUL;
					end else begin
						unique case (stage_q)
							eov_pkg::STG_ATTACK: begin
								neg_q <= level_q > target_q;
								mul_b_q <= (level_q > target_q) ? level_q - target_q
									: target_q - level_q;
								mul_a_q <= MA'(atk_m_q);
								op_q <= OP_ATK;
								mul_p_q <= '0;
								mul_cnt_q <= MC_W'(MB);
								state_q <= ST_MUL;
							end
							eov_pkg::STG_SUSTAIN: begin
								if (hold_q != 24'd0) hold_q <= hold_q - 1'b1;
								if (hold_q <= 24'd1) stage_q <= eov_pkg::STG_RELEASE;
								state_q <= ST_WAVE;
							end
							eov_pkg::STG_RELEASE: begin
								mul_a_q <= MA'(rel_m_q);
								mul_b_q <= level_q;
								op_q <= OP_REL;
								mul_p_q <= '0;
								mul_cnt_q <= MC_W'(MB);
								state_q <= ST_MUL;
							end
							default: begin
								sounding_q <= 1'b0;
								level_q <= '0;
								stage_q <= eov_pkg::STG_IDLE;
								state_q <= ST_WAVE;
							end
						endcase
					end
				end
				ST_MUL: begin
					mul_p_q <= {mul_sum, mul_p_q[MB-1:1]};
					mul_b_q <= mul_b_q >> 1;
					mul_cnt_q <= mul_cnt_q - 1'b1;
					if (mul_cnt_q == MC_W'(1)) state_q <= ST_MDONE;
				end
				ST_MDONE: begin
					unique case (op_q)
						OP_DECAY, OP_REL: begin
							// release switch-off zeroes the gain, decay keeps it
							level_q <= (lvl_dec < thresh_q && op_q == OP_REL) ? '0 : lvl_dec;
							if (lvl_dec < thresh_q) begin
								sounding_q <= 1'b0;
								stage_q <= eov_pkg::STG_IDLE;
							end
							state_q <= ST_WAVE;
						end
						OP_ATK: begin
							level_q <= neg_q ? target_q + q24 : target_q - q24;
							mul_a_q <= MA'(fraction_q);
							mul_b_q <= target_q;
							op_q <= OP_CMP;
							mul_p_q <= '0;
							mul_cnt_q <= MC_W'(MB);
							state_q <= ST_MUL;
						end
						OP_CMP: begin
							// attack done once level*2^16 passes target*fraction
							if (PW_P'({level_q, 16'h0000}) > mul_p_q) begin
								level_q <= target_q;
								stage_q <= eov_pkg::STG_SUSTAIN;
							end
							state_q <= ST_WAVE;
						end
						OP_SIN: begin
							wave_q <= wave_q + WAVE_W'(sin_v);
							phase_q[k_idx] <= phase_q[k_idx] + step_q[k_idx];
							k_q <= k_q + 1'b1;
							state_q <= (k_q + 1'b1 == osc_n_q) ? ST_OUT : ST_SINA;
						end
						OP_OUT: begin
							res_smp_q <= smp;
							res_act_q <= sounding_q;
							state_q <= ST_FIN;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_WAVE: begin
					unique case (wave_sel_q)
						eov_pkg::WAVE_SQUARE: begin
							wave_q <= phase_q[0][PHASE_WIDTH-1] ? -WAVE_W'(32768)
								: WAVE_W'(32768);
							phase_q[0] <= phase_q[0] + step_q[0];
							state_q <= ST_OUT;
						end
						eov_pkg::WAVE_TRIANGLE: begin
							wave_q <= WAVE_W'(tri_v);
							phase_q[0] <= phase_q[0] + step_q[0];
							state_q <= ST_OUT;
						end
						eov_pkg::WAVE_NOISE: begin
							noise_q <= nx3;
							wave_q <= WAVE_W'($signed({3'b000, nx3[15:0]})) - WAVE_W'(32768);
							phase_q[0] <= phase_q[0] + step_q[0];
							state_q <= ST_OUT;
						end
						default: begin
							wave_q <= '0;
							k_q <= '0;
							state_q <= ST_SINA;
						end
					endcase
				end
				ST_SINA: begin
					sin_a_q <= tab_val;
					state_q <= ST_SINB;
				end
				ST_SINB: begin
					neg_q <= tab_val < sin_a_q;
					mul_b_q <= (tab_val < sin_a_q) ? 17'(18'(sin_a_q) - 18'(tab_val))
						: 17'(18'(tab_val) - 18'(sin_a_q));
					mul_a_q <= MA'(ph_k[FRAC_W-1:0]);
					op_q <= OP_SIN;
					mul_p_q <= '0;
					mul_cnt_q <= MC_W'(MB);
					state_q <= ST_MUL;
				end
				ST_OUT: begin
					neg_q <= wave_q[WAVE_W-1];
					mul_a_q <= MA'(wave_abs);
					mul_b_q <= level_q;
					op_q <= OP_OUT;
					mul_p_q <= '0;
					mul_cnt_q <= MC_W'(MB);
					state_q <= ST_MUL;
				end
				ST_FIN: begin
					if (out_load) begin
						sample_q <= res_smp_q;
						active_q <= res_act_q;
						stage_out_q <= stage_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign voice_active = active_q;
	assign stage_out    = stage_out_q;

`include "envelope_oscillator_voice_assert.svh"

	`EOV_ASSERT_NOW(a_sustain_adsr, stage_q == eov_pkg::STG_SUSTAIN, adsr_q)
	`EOV_ASSERT_NEXT(a_fin_leaves_beat, state_q == ST_FIN, state_q == ST_FIN || out_valid_q)
	`EOV_ASSERT_NOW(a_osc_range, 1'b1, osc_n_q >= 1 && osc_n_q <= OSC_MAX)

endmodule
